// ===== sv/fscm_pkg.sv =====
// ----------------------------------------------------------------------------
// fscm_pkg
// Shared types and constants for the flex sensor calibrate-and-map block.
// ----------------------------------------------------------------------------
package fscm_pkg;

    localparam int CHANNELS   = 5;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 12;
    localparam int ANGLE_W    = 8;
    localparam int CHAN_W     = 3;

    localparam logic [11:0] MV_SCALE   = 12'd3300;
    localparam logic [11:0] MAX_LIMIT  = 12'd3295;
    localparam logic [11:0] MIN_LIMIT  = 12'd5;
    localparam int          SPAN0_MIN  = 50;
    localparam int          SPAN_MIN   = 70;

    localparam logic [11:0] RST_MAX    = 12'd200;
    localparam logic [11:0] RST_MIN    = 12'd30;
    localparam logic [11:0] RST_SPAN   = 12'd70;

    // floor(x / 20) == (x * CUT_RECIP) >> 16 for x below 4115
    localparam logic [11:0] CUT_RECIP  = 12'd3277;

    localparam int DIV_NUM_W  = 23;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    typedef enum logic [1:0] {
        KIND_MEASURE = 2'd0,
        KIND_CAL     = 2'd1,
        KIND_START   = 2'd2,
        KIND_CHECK   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORTED = 2'd1,
        ST_OPEN    = 2'd2,
        ST_WIDTH   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_PREP,
        S_DIV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_END,
        S_CMT_RD,
        S_CMT_CALC,
        S_CMT_WR,
        S_DONE
    } t_state;

endpackage

// ===== sv/flex_sensor_calibrate_and_map.sv =====
// ----------------------------------------------------------------------------
// flex_sensor_calibrate_and_map
// Per-channel flex sensor conversion, calibration tracking and limit commit.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one item: kind, channel and a
// 12-bit ADC code. Output channel (o_valid / i_ready) returns exactly one
// transaction per item: millivolts, angle, check status and commit flag.
// Items are handled one at a time; o_ready is high while the sequencer idles,
// so the next item is accepted in the cycle after the result register loads.
// Per-channel limits live in a 5-entry active memory and tracked min/max in
// a 5-entry track memory, both read through a registered output.
// Steps from accept to result register:
//   start item, or sample on a channel out of range: straight to the result
//   calibration sample: read, update and write back
//   measure sample: read and clamp, done there for a zero span or a value
//   below min after the clamp, else the 23-step bit-serial divider
//   check item: a read and an evaluate step per channel for the scan, plus
//   read, cut and write per channel for the commit pass when it commits
// A finished result waits in the output register while the next item is
// accepted; a stalled receiver blocks only when a second result is ready.
// Reset restores active limits (max 200, min 30, span 70) through per-entry
// valid bits and clears the seeded flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flex_sensor_calibrate_and_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic [fscm_pkg::CHAN_W-1:0]   i_channel,
    input  logic [fscm_pkg::SAMPLE_W-1:0] i_raw_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fscm_pkg::MV_W-1:0]     o_millivolts,
    output logic [fscm_pkg::ANGLE_W-1:0]  o_angle,
    output logic [1:0]                    o_check_status,
    output logic                          o_committed
);

    localparam int IW = fscm_pkg::CH_IDX_W;

    fscm_pkg::t_state r_state, n_state;

    // item registers
    fscm_pkg::t_kind            r_kind;
    logic [IW-1:0]              r_ch;
    logic [11:0]                r_mv;
    logic [7:0]                 r_angle;
    fscm_pkg::t_status          r_status;
    logic                       r_commit;

    // measure path
    logic [11:0]                r_d;
    logic                       r_seg;

    // scan / commit
    logic [IW-1:0]              r_idx;
    logic                       r_found;
    logic                       r_span0_bad;
    logic                       r_other_bad;
    logic [11:0]                r_cut;

    // output register
    logic                       r_o_valid;
    logic [11:0]                r_o_mv;
    logic [7:0]                 r_o_angle;
    logic [1:0]                 r_o_status;
    logic                       r_o_commit;

    // memories
    logic [35:0]                act_mem [fscm_pkg::CHANNELS];
    logic [23:0]                trk_mem [fscm_pkg::CHANNELS];
    logic [fscm_pkg::CHANNELS-1:0] r_act_vld;
    logic [fscm_pkg::CHANNELS-1:0] r_seeded;
    logic [35:0]                r_act_q;
    logic                       r_act_vld_q;
    logic [23:0]                r_trk_q;

    logic [IW-1:0]              rd_addr;
    logic                       accept;
    logic                       in_ch_ok;
    logic                       is_last;
    logic                       done_load;
    logic [23:0]                mv_prod;

    logic [11:0]                act_max, act_min, act_span;
    logic [11:0]                trk_max, trk_min;

    logic [11:0]                v_lo, v_cl;
    logic                       m_zero, m_neg;

    logic [16:0]                d20, s7;
    logic [15:0]                s13;
    logic [fscm_pkg::DIV_NUM_W-1:0] div_num;
    logic [fscm_pkg::DIV_DEN_W-1:0] div_den;
    logic                       seg_hi;
    logic                       div_start;
    logic                       div_done;
    logic [fscm_pkg::DIV_NUM_W-1:0] div_quo;
    logic [23:0]                a_full;

    logic [12:0]                diff;
    logic [11:0]                span12;
    logic [24:0]                cut_prod;
    logic [11:0]                new_max, new_min;
    logic [11:0]                cal_max, cal_min;

    // control decode
    logic                       trk_we;
    logic                       act_we;

    assign accept   = i_valid && o_ready;
    assign in_ch_ok = ({29'd0, i_channel} < fscm_pkg::CHANNELS);
    assign is_last  = (r_idx == IW'(fscm_pkg::CHANNELS - 1));
    assign mv_prod  = 24'(i_raw_sample) * 24'(fscm_pkg::MV_SCALE);
    assign done_load = (r_state == fscm_pkg::S_DONE) && (!r_o_valid || i_ready);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fscm_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (fscm_pkg::t_kind'(i_kind))
                        fscm_pkg::KIND_MEASURE,
                        fscm_pkg::KIND_CAL:   n_state = in_ch_ok ? fscm_pkg::S_RD
                                                                 : fscm_pkg::S_DONE;
                        fscm_pkg::KIND_START: n_state = fscm_pkg::S_DONE;
                        fscm_pkg::KIND_CHECK: n_state = fscm_pkg::S_SCAN_RD;
                        default:              n_state = fscm_pkg::S_DONE;
                    endcase
                end
            end
            fscm_pkg::S_RD:   n_state = fscm_pkg::S_EXEC;
            fscm_pkg::S_EXEC: begin
                if (r_kind == fscm_pkg::KIND_CAL || m_zero || m_neg) begin
                    n_state = fscm_pkg::S_DONE;
                end else begin
                    n_state = fscm_pkg::S_PREP;
                end
            end
            fscm_pkg::S_PREP: n_state = fscm_pkg::S_DIV;
            fscm_pkg::S_DIV:  if (div_done) n_state = fscm_pkg::S_DONE;
            fscm_pkg::S_SCAN_RD: n_state = fscm_pkg::S_SCAN_EV;
            fscm_pkg::S_SCAN_EV: n_state = is_last ? fscm_pkg::S_SCAN_END
                                                   : fscm_pkg::S_SCAN_RD;
            fscm_pkg::S_SCAN_END: begin
                if (r_found || r_span0_bad || r_other_bad) begin
                    n_state = fscm_pkg::S_DONE;
                end else begin
                    n_state = fscm_pkg::S_CMT_RD;
                end
            end
            fscm_pkg::S_CMT_RD:   n_state = fscm_pkg::S_CMT_CALC;
            fscm_pkg::S_CMT_CALC: n_state = fscm_pkg::S_CMT_WR;
            fscm_pkg::S_CMT_WR:   n_state = is_last ? fscm_pkg::S_DONE
                                                    : fscm_pkg::S_CMT_RD;
            fscm_pkg::S_DONE:     if (done_load) n_state = fscm_pkg::S_IDLE;
            default:              n_state = fscm_pkg::S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        o_ready   = (r_state == fscm_pkg::S_IDLE);
        trk_we    = (r_state == fscm_pkg::S_EXEC) && (r_kind == fscm_pkg::KIND_CAL);
        act_we    = (r_state == fscm_pkg::S_CMT_WR);
        div_start = (r_state == fscm_pkg::S_PREP);
        unique case (r_state)
            fscm_pkg::S_SCAN_RD, fscm_pkg::S_SCAN_EV,
            fscm_pkg::S_CMT_RD, fscm_pkg::S_CMT_CALC,
            fscm_pkg::S_CMT_WR: rd_addr = r_idx;
            default:            rd_addr = r_ch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fscm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- memories ----------------
    assign act_max  = r_act_vld_q ? r_act_q[35:24] : fscm_pkg::RST_MAX;
    assign act_min  = r_act_vld_q ? r_act_q[23:12] : fscm_pkg::RST_MIN;
    assign act_span = r_act_vld_q ? r_act_q[11:0]  : fscm_pkg::RST_SPAN;
    assign trk_max  = r_trk_q[23:12];
    assign trk_min  = r_trk_q[11:0];

    always_ff @(posedge i_clk) begin
        r_act_q     <= act_mem[rd_addr];
        r_act_vld_q <= r_act_vld[rd_addr];
        r_trk_q     <= trk_mem[rd_addr];
        if (act_we) begin
            act_mem[r_idx] <= {new_max, new_min, span12};
        end
        if (trk_we) begin
            trk_mem[r_ch] <= {cal_max, cal_min};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_vld <= '0;
            r_seeded  <= '0;
        end else begin
            if (act_we) begin
                r_act_vld[r_idx] <= 1'b1;
            end
            if (accept && (i_kind == fscm_pkg::KIND_START
                           || i_kind == fscm_pkg::KIND_CHECK)) begin
                r_seeded <= '0;
            end else if (trk_we) begin
                r_seeded[r_ch] <= 1'b1;
            end
        end
    end

    // ---------------- datapath ----------------
    // calibration update: seed on first sample, then widen
    always_comb begin
        if (!r_seeded[r_ch]) begin
            cal_max = r_mv;
            cal_min = r_mv;
        end else begin
            cal_max = (r_mv > trk_max) ? r_mv : trk_max;
            cal_min = (r_mv < trk_min) ? r_mv : trk_min;
        end
    end

    // clamp to active limits
    always_comb begin
        v_lo   = (r_mv < act_min) ? act_min : r_mv;
        v_cl   = (v_lo > act_max) ? act_max : v_lo;
        m_zero = (act_span == 12'd0);
        m_neg  = (v_cl < act_min);
    end

    // divider operands for the two segments
    always_comb begin
        d20    = 17'(r_d) * 17'd20;
        s7     = 17'(act_span) * 17'd7;
        s13    = 16'(act_span) * 16'd13;
        seg_hi = (d20 >= s7);
        if (seg_hi) begin
            div_num = fscm_pkg::DIV_NUM_W'(d20 - s7) * fscm_pkg::DIV_NUM_W'(90);
            div_den = s13;
        end else begin
            div_num = fscm_pkg::DIV_NUM_W'(r_d) * fscm_pkg::DIV_NUM_W'(1800);
            div_den = s7[15:0];
        end
    end

    assign a_full = 24'(div_quo) + (r_seg ? 24'd90 : 24'd0);

    fscm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // check and commit arithmetic
    always_comb begin
        diff     = {1'b0, trk_max} - {1'b0, trk_min};
        span12   = diff[11:0];
        cut_prod = 25'(13'(span12) + 13'd19) * 25'(fscm_pkg::CUT_RECIP);
        new_max  = (trk_max >= r_cut) ? trk_max - r_cut : 12'd0;
        new_min  = (trk_min >= r_cut) ? trk_min - r_cut : 12'd0;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fscm_pkg::S_IDLE: begin
                if (accept) begin
                    r_kind      <= fscm_pkg::t_kind'(i_kind);
                    r_ch        <= IW'(i_channel);
                    r_mv        <= (i_kind == fscm_pkg::KIND_MEASURE
                                    || i_kind == fscm_pkg::KIND_CAL) ? mv_prod[23:12]
                                                                     : 12'd0;
                    r_angle     <= 8'd0;
                    r_status    <= fscm_pkg::ST_OK;
                    r_commit    <= 1'b0;
                    r_idx       <= '0;
                    r_found     <= 1'b0;
                    r_span0_bad <= 1'b0;
                    r_other_bad <= 1'b0;
                end
            end
            fscm_pkg::S_EXEC: begin
                r_d <= v_cl - act_min;
                // below-min after clamp maps to zero degrees before the flip
                if (r_kind == fscm_pkg::KIND_MEASURE && !m_zero && m_neg) begin
                    r_angle <= 8'd180;
                end
            end
            fscm_pkg::S_PREP: r_seg <= seg_hi;
            fscm_pkg::S_DIV: begin
                if (div_done) begin
                    r_angle <= (a_full >= 24'd180) ? 8'd0 : 8'(24'd180 - a_full);
                end
            end
            fscm_pkg::S_SCAN_EV: begin
                if (!r_found) begin
                    if (trk_max > fscm_pkg::MAX_LIMIT) begin
                        r_found  <= 1'b1;
                        r_status <= fscm_pkg::ST_SHORTED;
                    end else if (trk_min < fscm_pkg::MIN_LIMIT) begin
                        r_found  <= 1'b1;
                        r_status <= fscm_pkg::ST_OPEN;
                    end
                end
                if (r_idx == '0) begin
                    if ($signed(diff) < 13'sd50) r_span0_bad <= 1'b1;
                end else begin
                    if ($signed(diff) < 13'sd70) r_other_bad <= 1'b1;
                end
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
            fscm_pkg::S_SCAN_END: begin
                if (!r_found && r_span0_bad) r_status <= fscm_pkg::ST_WIDTH;
            end
            fscm_pkg::S_CMT_CALC: r_cut <= 12'(cut_prod[24:16]);
            fscm_pkg::S_CMT_WR: begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
                if (is_last) r_commit <= 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (done_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_load) begin
            r_o_mv     <= r_mv;
            r_o_angle  <= (r_kind == fscm_pkg::KIND_MEASURE) ? r_angle : 8'd0;
            r_o_status <= r_status;
            r_o_commit <= r_commit;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_millivolts   = r_o_mv;
    assign o_angle        = r_o_angle;
    assign o_check_status = r_o_status;
    assign o_committed    = r_o_commit;

endmodule

// ===== sv/fscm_div.sv =====
// ----------------------------------------------------------------------------
// fscm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fscm_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [fscm_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [fscm_pkg::DIV_DEN_W-1:0]     i_den,
    output logic                               o_done,
    output logic [fscm_pkg::DIV_NUM_W-1:0]     o_quo
);

    logic [fscm_pkg::DIV_NUM_W-1:0] r_quo;
    logic [fscm_pkg::DIV_DEN_W-1:0] r_rem;
    logic [fscm_pkg::DIV_DEN_W-1:0] r_den;
    logic [fscm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [fscm_pkg::DIV_DEN_W:0]   trial;
    logic                           take;

    assign trial = {r_rem, r_quo[fscm_pkg::DIV_NUM_W-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fscm_pkg::DIV_CNT_W'(fscm_pkg::DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fscm_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            // shift in the next numerator bit, subtract when it fits
            r_quo <= {r_quo[fscm_pkg::DIV_NUM_W-2:0], take};
            r_rem <= take ? fscm_pkg::DIV_DEN_W'(trial - {1'b0, r_den})
                          : trial[fscm_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== test/flex_sensor_calibrate_and_map_test.sv =====
// ----------------------------------------------------------------------------
// flex_sensor_calibrate_and_map_test
// Self-checking bench: drives measure, calibration, start and check items,
// predicts every result transaction and compares it field by field.
// ----------------------------------------------------------------------------
module flex_sensor_calibrate_and_map_test;

    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic [11:0] mv;
        logic [7:0]  angle;
        logic [1:0]  status;
        logic        committed;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = 2'd0;
    logic [2:0]  i_channel = 3'd0;
    logic [11:0] i_raw_sample = 12'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_millivolts;
    logic [7:0]  o_angle;
    logic [1:0]  o_check_status;
    logic        o_committed;

    flex_sensor_calibrate_and_map dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    int unsigned lim_max [fscm_pkg::CHANNELS];
    int unsigned lim_min [fscm_pkg::CHANNELS];
    int unsigned lim_span[fscm_pkg::CHANNELS];
    int unsigned trk_max [fscm_pkg::CHANNELS];
    int unsigned trk_min [fscm_pkg::CHANNELS];
    bit          trk_seed[fscm_pkg::CHANNELS];

    t_result pending_results[$];
    int      failures = 0;
    int      cycles = 0;
    bit      idle_on = 1'b1;
    bit      hold_on = 1'b0;
    int      stall_left = 0;

    function automatic int unsigned code_to_mv(logic [11:0] code);
        return (int'(code) * 3300) >> 12;
    endfunction

    function automatic int unsigned bend_angle(int ch, int unsigned mv);
        longint v, d, s, a;
        v = mv;
        if (v < lim_min[ch]) v = lim_min[ch];
        if (v > lim_max[ch]) v = lim_max[ch];
        s = lim_span[ch];
        if (s == 0) return 0;
        d = v - lim_min[ch];
        if (d < 0) a = 0;
        else if (20 * d < 7 * s) a = (1800 * d) / (7 * s);
        else a = 90 + (90 * (20 * d - 7 * s)) / (13 * s);
        a = 180 - a;
        if (a < 0) a = 0;
        return 32'(a);
    endfunction

    function automatic fscm_pkg::t_status check_limits(output bit done);
        int unsigned span, cut;
        done = 1'b0;
        for (int i = 0; i < fscm_pkg::CHANNELS; i++) begin
            if (trk_max[i] > 3295) return fscm_pkg::ST_SHORTED;
            if (trk_min[i] < 5) return fscm_pkg::ST_OPEN;
        end
        if (int'(trk_max[0]) - int'(trk_min[0]) < fscm_pkg::SPAN0_MIN)
            return fscm_pkg::ST_WIDTH;
        for (int i = 1; i < fscm_pkg::CHANNELS; i++)
            if (int'(trk_max[i]) - int'(trk_min[i]) < fscm_pkg::SPAN_MIN)
                return fscm_pkg::ST_OK;
        for (int i = 0; i < fscm_pkg::CHANNELS; i++) begin
            span = (trk_max[i] - trk_min[i]) & 12'hFFF;
            cut = (span + 19) / 20;
            lim_span[i] = span;
            lim_max[i] = (trk_max[i] >= cut) ? trk_max[i] - cut : 0;
            lim_min[i] = (trk_min[i] >= cut) ? trk_min[i] - cut : 0;
        end
        done = 1'b1;
        return fscm_pkg::ST_OK;
    endfunction

    function automatic t_result predict_item(fscm_pkg::t_kind kind, logic [2:0] ch,
                                             logic [11:0] code);
        t_result r;
        bit      done;
        int unsigned mv;
        mv = code_to_mv(code);
        r = '0;
        case (kind)
            fscm_pkg::KIND_MEASURE: begin
                r.mv = 12'(mv);
                if (ch < fscm_pkg::CHANNELS) r.angle = 8'(bend_angle(ch, mv));
            end
            fscm_pkg::KIND_CAL: begin
                r.mv = 12'(mv);
                if (ch < fscm_pkg::CHANNELS) begin
                    if (!trk_seed[ch]) begin
                        trk_seed[ch] = 1'b1;
                        trk_max[ch] = mv;
                        trk_min[ch] = mv;
                    end
                    if (mv > trk_max[ch]) trk_max[ch] = mv;
                    if (mv < trk_min[ch]) trk_min[ch] = mv;
                end
            end
            fscm_pkg::KIND_START: begin
                for (int i = 0; i < fscm_pkg::CHANNELS; i++) trk_seed[i] = 1'b0;
            end
            default: begin
                r.status = check_limits(done);
                r.committed = done;
                for (int i = 0; i < fscm_pkg::CHANNELS; i++) trk_seed[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    // send one transaction and record its expectation; valid stays up
    // until the next item or an idle gap replaces it
    task automatic send_item(fscm_pkg::t_kind kind, logic [2:0] ch, logic [11:0] code);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_channel <= ch;
        i_raw_sample <= code;
        pending_results.push_back(predict_item(kind, ch, code));
        do @(posedge i_clk); while (!o_ready);
    endtask

    // receiver: random stall bursts, plus a long hold-off when requested
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_on) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation waiting");
                failures++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_millivolts !== exp_r.mv) begin
                    $error("millivolts exp %0d got %0d", exp_r.mv, o_millivolts);
                    failures++;
                end
                if (o_angle !== exp_r.angle) begin
                    $error("angle exp %0d got %0d", exp_r.angle, o_angle);
                    failures++;
                end
                if (o_check_status !== exp_r.status) begin
                    $error("check_status exp %0d got %0d", exp_r.status,
                           o_check_status);
                    failures++;
                end
                if (o_committed !== exp_r.committed) begin
                    $error("committed exp %0d got %0d", exp_r.committed,
                           o_committed);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("flex_sensor_calibrate_and_map_test NOT OK");
            $finish;
        end
    end

    function automatic logic [11:0] mv_to_code(int unsigned mv);
        // smallest code whose conversion reaches mv
        return 12'(((mv << 12) + 3299) / 3300);
    endfunction

    // seed every channel with a range [lo_mv, lo_mv+w], top capped at 3299
    task automatic cal_sweep(int unsigned lo_mv, int unsigned w, int extra);
        int unsigned top;
        send_item(fscm_pkg::KIND_START, 3'($urandom), 12'($urandom));
        for (int c = 0; c < fscm_pkg::CHANNELS; c++) begin
            top = lo_mv + w;
            if (top > 3299) top = 3299;
            send_item(fscm_pkg::KIND_CAL, 3'(c), mv_to_code(lo_mv));
            send_item(fscm_pkg::KIND_CAL, 3'(c), mv_to_code(top));
            for (int k = 0; k < extra; k++)
                send_item(fscm_pkg::KIND_CAL, 3'(c),
                          mv_to_code($urandom_range(lo_mv, top)));
        end
    endtask

    task automatic test_directed;
        send_item(fscm_pkg::KIND_MEASURE, 3'd0, 12'h000);
        send_item(fscm_pkg::KIND_MEASURE, 3'd1, 12'hFFF);
        send_item(fscm_pkg::KIND_MEASURE, 3'd2, mv_to_code(60));
        send_item(fscm_pkg::KIND_MEASURE, 3'd3, mv_to_code(100));
        send_item(fscm_pkg::KIND_MEASURE, 3'd5, 12'hABC);
        send_item(fscm_pkg::KIND_CAL, 3'd7, 12'h555);
        send_item(fscm_pkg::KIND_MEASURE, 3'd6, 12'h2AA);
        // all channels pass, commit
        cal_sweep(100, 1000, 0);
        send_item(fscm_pkg::KIND_CHECK, 3'd7, 12'hFFF);
        send_item(fscm_pkg::KIND_MEASURE, 3'd0, 12'h000);
        send_item(fscm_pkg::KIND_MEASURE, 3'd4, 12'hFFF);
        // shorted: max above limit
        cal_sweep(100, 3199, 0);
        send_item(fscm_pkg::KIND_CHECK, 3'd0, 12'd0);
        // open: min too low
        cal_sweep(0, 500, 0);
        send_item(fscm_pkg::KIND_CHECK, 3'd0, 12'd0);
        // channel zero too narrow
        cal_sweep(500, 40, 0);
        send_item(fscm_pkg::KIND_CHECK, 3'd0, 12'd0);
    endtask

    task automatic test_zero_span;
        // channel 0 span exactly 50, others 70: narrowest ranges that commit
        send_item(fscm_pkg::KIND_START, 3'd0, 12'd0);
        for (int c = 0; c < fscm_pkg::CHANNELS; c++) begin
            send_item(fscm_pkg::KIND_CAL, 3'(c), mv_to_code(1000));
            send_item(fscm_pkg::KIND_CAL, 3'(c), mv_to_code(c == 0 ? 1050 : 1070));
        end
        send_item(fscm_pkg::KIND_CHECK, 3'd0, 12'd0);
        for (int k = 0; k < 20; k++)
            send_item(fscm_pkg::KIND_MEASURE, 3'($urandom_range(0, 4)),
                      mv_to_code($urandom_range(940, 1130)));
        // others too narrow: status ok, no commit
        cal_sweep(800, 60, 0);
        send_item(fscm_pkg::KIND_CHECK, 3'd0, 12'd0);
    endtask

    task automatic test_random(int n);
        int unsigned lo, w;
        int sent;
        int extra;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 3) != 0) begin
                lo = $urandom_range(0, 1500);
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120)
                                                : $urandom_range(40, 1900);
                extra = $urandom_range(0, 3);
                cal_sweep(lo, w, extra);
                sent += 1 + (2 + extra) * fscm_pkg::CHANNELS;
                if ($urandom_range(0, 5) != 0) begin
                    send_item(fscm_pkg::KIND_CHECK, 3'($urandom), 12'($urandom));
                    sent++;
                end
            end
            for (int k = 0; k < 12; k++) begin
                send_item(($urandom_range(0, 4) == 0) ? fscm_pkg::KIND_CAL
                                                      : fscm_pkg::KIND_MEASURE,
                          3'($urandom), 12'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure;
        // hold the receiver off for a long stretch in its own process
        fork
            begin
                hold_on <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join_none
        for (int k = 0; k < 12; k++)
            send_item(fscm_pkg::KIND_MEASURE, 3'($urandom_range(0, 4)), 12'($urandom));
    endtask

    initial begin
        for (int i = 0; i < fscm_pkg::CHANNELS; i++) begin
            lim_max[i] = 200;
            lim_min[i] = 30;
            lim_span[i] = 70;
            trk_max[i] = 0;
            trk_min[i] = 0;
            trk_seed[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_zero_span();
        test_backpressure();
        test_random(1200);
        idle_on <= 1'b0;
        test_random(150);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (failures == 0) begin
            $display("flex_sensor_calibrate_and_map_test OK");
        end else begin
            $display("flex_sensor_calibrate_and_map_test NOT OK");
        end
        $finish;
    end
endmodule
